### rtl/ptt_pkg.sv
// ptt_pkg: shared types and constants for the periodic task table
// used by ptt_cell, ptt_head, periodic_task_table and ptt_checker
`default_nettype none

package ptt_pkg;

    localparam int PTT_MAX_TASKS    = 16;
    localparam int PTT_RESULT_LIMIT = 16;
    localparam int PTT_NUM_W        = $clog2(PTT_RESULT_LIMIT + 1);

    // input actions
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_CREATE   = 2'd1;
    localparam logic [1:0] ACT_DELETE   = 2'd2;
    localparam logic [1:0] ACT_DISPATCH = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TASK   = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_id;
        logic [15:0] period;
    } ptt_in_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] ready_id;
        logic       ok;
        logic       last;
    } ptt_out_t;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] period;
        logic [15:0] ticks;
        logic        ready;
    } ptt_entry_t;

    // status from the head unit to the sequencer
    typedef struct packed {
        logic match;   // identifier found in an active slot
        logic hit;     // ready entry dispatched at this step
        logic place;   // new entry written at this step
    } ptt_head_flags_t;

endpackage

`default_nettype wire

### rtl/ptt_cell.sv
// ptt_cell: one slot of the task ring, holds a single entry
// depends on ptt_pkg
`default_nettype none

module ptt_cell
    import ptt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire ptt_entry_t entry_in,
    output ptt_entry_t      entry_out
);

    ptt_entry_t entry_reg;

    // payload only, no reset
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

`default_nettype wire

### rtl/ptt_head.sv
// ptt_head: per-step update of the entry leaving the front of the ring
// depends on ptt_pkg
`default_nettype none

module ptt_head
    import ptt_pkg::*;
#(
    parameter int MAX_TASKS = PTT_MAX_TASKS,
    localparam int PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input  wire logic [1:0]    action,
    input  wire logic [7:0]    task_id,
    input  wire logic [15:0]   period,
    input  wire logic [PW-1:0] pos,
    input  wire logic [CW-1:0] count,
    input  wire logic          found,
    input  wire logic          room,
    input  wire ptt_entry_t    front,
    input  wire ptt_entry_t    second,
    output ptt_entry_t         push,
    output ptt_head_flags_t    flags
);

    logic active;
    logic at_end;

    assign active = CW'(pos) < count;
    assign at_end = CW'(pos) == count;

    always_comb begin
        push        = front;
        flags       = '0;
        flags.match = active && (front.ident == task_id) && !found;
        unique case (action)
            ACT_TICK: begin
                if (active) begin
                    if (front.ticks < front.period) begin
                        push.ticks = front.ticks + 16'd1;
                    end else if (front.ticks == front.period) begin
                        push.ticks = '0;
                        push.ready = 1'b1;
                    end
                end
            end
            ACT_CREATE: begin
                // slot just past the active ones, only reached while not full
                flags.place = at_end && !found;
                if (flags.place) begin
                    push.ident  = task_id;
                    push.period = period;
                    push.ticks  = '0;
                    push.ready  = 1'b0;
                end
            end
            ACT_DELETE: begin
                // from the match on, skip one slot so later entries move down
                if (found || flags.match) begin
                    push = second;
                end
            end
            ACT_DISPATCH: begin
                flags.hit = active && front.ready && room;
                if (flags.hit) begin
                    push.ready = 1'b0;
                end
            end
            default: begin
                push = front;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/periodic_task_table.sv
// periodic_task_table: top level of the periodic task table
// depends on ptt_pkg, ptt_cell, ptt_head
`default_nettype none

// The table lives in a ring of MAX_TASKS cells. Every item walks the whole
// ring once: at each step the front entry passes through the head unit, is
// updated for the current action and re-enters at the back, so after
// MAX_TASKS steps the table is back in slot order. A tick advances every
// active entry and gives no transaction on the result side. Create and
// delete give one status transaction. Dispatch gives one transaction per
// ready task in table order (at most 16, last set on the final one), or a
// single "no task ready" transaction. An item walks the ring in ST_WALK,
// posts its final result in ST_FINISH and returns to ST_IDLE to take the
// next item; a tick posts nothing and goes from ST_WALK straight back to
// ST_IDLE. A dispatch walk pauses at a step that must pass a result on
// while the result register is full and the consumer holds m_ready low,
// and the final result waits the same way. Input items are accepted only
// between walks. One result register sits on the output, so a finished
// result can wait for the consumer while the next item is taken. The table
// contents are not cleared by reset; the active count and the sequencer
// state are, and only active slots are ever read.

module periodic_task_table
    import ptt_pkg::*;
#(
    parameter int MAX_TASKS = PTT_MAX_TASKS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ptt_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ptt_out_t      m_data
);

    localparam int PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // sequencer registers
    state_t               state_reg, state_next;
    ptt_in_t              item_reg, item_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 found_reg, found_next;     // match seen in this walk
    logic                 placed_reg, placed_next;   // create wrote its entry
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_id_reg, pend_id_next;
    logic [PTT_NUM_W-1:0] num_reg, num_next;         // dispatched so far
    logic                 m_valid_reg, m_valid_next;
    ptt_out_t             m_data_reg, m_data_next;

    // ring
    ptt_entry_t      cell_q [MAX_TASKS];
    ptt_entry_t      cell_d [MAX_TASKS];
    ptt_entry_t      second;
    ptt_entry_t      push;
    ptt_head_flags_t flags;

    logic out_free;
    logic emit_walk;
    logic advance;
    logic last_step;

    // ring of cells, front at index 0, entries move toward the front
    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            if (gi == MAX_TASKS - 1) begin : g_back
                assign cell_d[gi] = push;
            end else begin : g_mid
                assign cell_d[gi] = cell_q[gi + 1];
            end
            ptt_cell u_cell (
                .aclk      (aclk),
                .shift_en  (advance),
                .entry_in  (cell_d[gi]),
                .entry_out (cell_q[gi])
            );
        end
        if (MAX_TASKS > 1) begin : g_second
            assign second = cell_q[1];
        end else begin : g_single
            assign second = cell_q[0];
        end
    endgenerate

    ptt_head #(
        .MAX_TASKS (MAX_TASKS)
    ) u_head (
        .action  (item_reg.action),
        .task_id (item_reg.task_id),
        .period  (item_reg.period),
        .pos     (pos_reg),
        .count   (count_reg),
        .found   (found_reg),
        .room    (num_reg < PTT_NUM_W'(PTT_RESULT_LIMIT)),
        .front   (cell_q[0]),
        .second  (second),
        .push    (push),
        .flags   (flags)
    );

    assign out_free  = !m_valid_reg || m_ready;
    // a newly found ready task pushes the held one out with last clear
    assign emit_walk = (state_reg == ST_WALK) && (item_reg.action == ACT_DISPATCH)
                       && flags.hit && pend_valid_reg;
    assign advance   = (state_reg == ST_WALK) && (!emit_walk || out_free);
    assign last_step = pos_reg == PW'(MAX_TASKS - 1);

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        placed_next     = placed_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        num_next        = num_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next       = s_data;
                    pos_next        = '0;
                    found_next      = 1'b0;
                    placed_next     = 1'b0;
                    pend_valid_next = 1'b0;
                    num_next        = '0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK: begin
                if (advance) begin
                    if (flags.match) begin
                        found_next = 1'b1;
                    end
                    if (flags.place) begin
                        placed_next = 1'b1;
                    end
                    if (flags.hit) begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = cell_q[0].ident;
                        num_next        = num_reg + PTT_NUM_W'(1);
                    end
                    if (emit_walk) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{result_kind: KIND_TASK, ready_id: pend_id_reg,
                                         ok: 1'b1, last: 1'b0};
                    end
                    pos_next = last_step ? '0 : pos_reg + PW'(1);
                    if (last_step) begin
                        state_next = (item_reg.action == ACT_TICK) ? ST_IDLE : ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    unique case (item_reg.action)
                        ACT_CREATE: begin
                            m_data_next = '{result_kind: KIND_STATUS, ready_id: 8'd0,
                                            ok: placed_reg, last: 1'b1};
                            if (placed_reg) begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_DELETE: begin
                            m_data_next = '{result_kind: KIND_STATUS, ready_id: 8'd0,
                                            ok: found_reg, last: 1'b1};
                            if (found_reg) begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default: begin
                            if (pend_valid_reg) begin
                                m_data_next = '{result_kind: KIND_TASK,
                                                ready_id: pend_id_reg,
                                                ok: 1'b1, last: 1'b1};
                            end else begin
                                m_data_next = '{result_kind: KIND_NONE, ready_id: 8'd0,
                                                ok: 1'b0, last: 1'b1};
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            placed_reg     <= 1'b0;
            num_reg        <= '0;
            pos_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            placed_reg     <= placed_next;
            num_reg        <= num_next;
            pos_reg        <= pos_next;
        end
        // payload
        item_reg    <= item_next;
        pend_id_reg <= pend_id_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### rtl/ptt_checker.sv
// ptt_checker: port-level checks for periodic_task_table, bound to the top
// depends on ptt_pkg
`default_nettype none

module ptt_checker
    import ptt_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire ptt_out_t m_data
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time: no second input transaction right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken during a walk");

    // status results are single and carry no identifier
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == KIND_STATUS) |-> m_data.last
        && (m_data.ready_id == 8'd0))
        else $error("bad status result");

    // empty dispatch is a single result with ok clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == KIND_NONE) |-> m_data.last && !m_data.ok
        && (m_data.ready_id == 8'd0))
        else $error("bad empty dispatch result");

    // dispatched tasks always report ok, and no undefined kind appears
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.result_kind == KIND_STATUS)
        || (m_data.result_kind == KIND_NONE)
        || ((m_data.result_kind == KIND_TASK) && m_data.ok))
        else $error("bad result kind");

endmodule

bind periodic_task_table ptt_checker u_ptt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
